[rtl/core/bgt_pkg.sv]
// Package for the battery gauge: item types, codes, constants and the OCV table.
package bgt_pkg;

  // Default sizes
  localparam int BATCH_SAMPLES_DEF  = 11;
  localparam int TRIM_EACH_SIDE_DEF = 2;
  localparam int TABLE_POINTS_DEF   = 20;

  // OCV table facts
  localparam int TABLE_HAVE = 20;
  localparam int SEG_W      = 5;
  localparam int MV_W       = 13;
  localparam int PCT_W      = 7;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Sample and filter widths
  localparam int SAMPLE_W = 12;
  localparam int FILT_W   = 17;
  localparam int Q14_W    = 28;

  // Validity window in 1/16384 mV, clamp window in 1/16 mV
  localparam logic [Q14_W-1:0]  VALID_LO_Q14 = 28'd45875200;
  localparam logic [Q14_W-1:0]  VALID_HI_Q14 = 28'd73728000;
  localparam logic [FILT_W-1:0] CLAMP_LO_16  = 17'd48000;
  localparam logic [FILT_W-1:0] CLAMP_HI_16  = 17'd68000;
  localparam logic [16:0]       ALPHA_ONE    = 17'd65536;
  localparam logic [33:0]       ROUND_HALF   = 34'd32768;

  // Shared divider sizes
  localparam int DIV_DW = 22;
  localparam int DIV_VW = 15;

  // Configuration
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN       = 3'd0,
    REG_ALPHA      = 3'd1,
    REG_LOW_ENTER  = 3'd2,
    REG_LOW_LEAVE  = 3'd3,
    REG_RISE       = 3'd4
  } cfg_reg_t;

  localparam logic [14:0] GAIN_RST       = 15'd16384;
  localparam logic [15:0] ALPHA_RST      = 16'd14418;
  localparam logic [6:0]  LOW_ENTER_RST  = 7'd8;
  localparam logic [6:0]  LOW_LEAVE_RST  = 7'd12;
  localparam logic [3:0]  RISE_RST       = 4'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_mv;
    logic                force_req;
  } bgt_in_t;

  typedef struct packed {
    logic             reading_valid;
    logic [13:0]      battery_mv;
    logic [12:0]      filtered_mv;
    logic [PCT_W-1:0] raw_percent;
    logic [PCT_W-1:0] shown_percent;
    logic             battery_low;
  } bgt_out_t;

  // Cell commands
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DRAIN
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [SAMPLE_W-1:0] sample;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_FILL,
    S_SUM,
    S_AVG,
    S_SCALE,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_CLAMP,
    S_SEEK,
    S_PCT,
    S_SLEW,
    S_OUT
  } bgt_state_t;

  // OCV table, highest voltage first
  function automatic logic [MV_W-1:0] ocv_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      5'd0:  v = 13'd4200;
      5'd1:  v = 13'd4150;
      5'd2:  v = 13'd4110;
      5'd3:  v = 13'd4080;
      5'd4:  v = 13'd4050;
      5'd5:  v = 13'd4020;
      5'd6:  v = 13'd3990;
      5'd7:  v = 13'd3960;
      5'd8:  v = 13'd3930;
      5'd9:  v = 13'd3900;
      5'd10: v = 13'd3870;
      5'd11: v = 13'd3840;
      5'd12: v = 13'd3810;
      5'd13: v = 13'd3780;
      5'd14: v = 13'd3750;
      5'd15: v = 13'd3720;
      5'd16: v = 13'd3690;
      5'd17: v = 13'd3650;
      5'd18: v = 13'd3550;
      5'd19: v = 13'd3400;
      default: v = 13'd3400;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] ocv_pct(input logic [SEG_W-1:0] idx);
    logic [PCT_W-1:0] p;
    case (idx)
      5'd0:  p = 7'd100;
      5'd1:  p = 7'd95;
      5'd2:  p = 7'd90;
      5'd3:  p = 7'd85;
      5'd4:  p = 7'd80;
      5'd5:  p = 7'd75;
      5'd6:  p = 7'd70;
      5'd7:  p = 7'd62;
      5'd8:  p = 7'd55;
      5'd9:  p = 7'd48;
      5'd10: p = 7'd40;
      5'd11: p = 7'd32;
      5'd12: p = 7'd24;
      5'd13: p = 7'd18;
      5'd14: p = 7'd13;
      5'd15: p = 7'd9;
      5'd16: p = 7'd6;
      5'd17: p = 7'd4;
      5'd18: p = 7'd2;
      5'd19: p = 7'd0;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

[rtl/core/bgt_cell.sv]
// One cell of the sorting row: holds one sample of the open batch.
module bgt_cell (
  input  logic                          clk,
  input  bgt_pkg::cell_ctl_t            ctl,
  input  logic                          occ,
  input  logic                          at_end,
  input  logic                          prev_gt,
  input  logic [bgt_pkg::SAMPLE_W-1:0]  prev_val,
  input  logic [bgt_pkg::SAMPLE_W-1:0]  next_val,
  output logic [bgt_pkg::SAMPLE_W-1:0]  val,
  output logic                          gt
);

  // held sample lies above the incoming one
  assign gt = occ && (val > ctl.sample);

  // insert: shift up behind a larger neighbour, or take the sample; drain: shift down
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      bgt_pkg::CELL_INSERT: begin
        if (prev_gt) begin
          val <= prev_val;
        end else if (gt || at_end) begin
          val <= ctl.sample;
        end
      end
      bgt_pkg::CELL_DRAIN: begin
        val <= next_val;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/bgt_div.sv]
// Restoring divider, one quotient bit per cycle.
module bgt_div #(
  parameter int DW = bgt_pkg::DIV_DW,
  parameter int VW = bgt_pkg::DIV_VW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

  logic [VW-1:0]    rem;
  logic [VW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [VW:0]      trial;
  logic             fits;

  // trial subtract of the next partial remainder
  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (run) begin
      rem      <= fits ? VW'(trial - {1'b0, dsr}) : trial[VW-1:0];
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

[rtl/core/battery_gauge_trimmed_ema_ocv.sv]
// Top level of the battery gauge: sorting row, batch sequencer and filter datapath.
//
//  channel   ports                          handshake
//  input     item (sample_mv, force_req)    start high, busy low at the clock edge
//  config    cfg_we, cfg_index, cfg_data    cfg_we high at the clock edge
//  result    result (six fields)            done high for one cycle
//
// A sample that does not close the batch is inserted in place by the cells.
// The closing sample starts the batch pass: drain of BATCH_SAMPLES cells, a reciprocal
// multiply for the average, the filter multiplies, a walk of up to TABLE_POINTS-1 table
// segments and a divide for the interpolation. busy stays high for the whole pass,
// which skips the filter and table steps on a rejected reading.
// Reset (rst, synchronous) empties the batch, unseeds the filter and loads register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
module battery_gauge_trimmed_ema_ocv #(
  parameter int BATCH_SAMPLES  = bgt_pkg::BATCH_SAMPLES_DEF,
  parameter int TRIM_EACH_SIDE = bgt_pkg::TRIM_EACH_SIDE_DEF,
  parameter int TABLE_POINTS   = bgt_pkg::TABLE_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  bgt_pkg::bgt_in_t                 item,
  input  logic                             cfg_we,
  input  logic [bgt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             done,
  output bgt_pkg::bgt_out_t                result
);

  localparam int N        = BATCH_SAMPLES;
  localparam int TRIM     = (2 * TRIM_EACH_SIDE >= N) ? (N - 1) / 2 : TRIM_EACH_SIDE;
  localparam int KEEP     = N - 2 * TRIM;
  localparam int CW       = $clog2(N + 1);
  localparam int SW       = bgt_pkg::SAMPLE_W + CW;
  localparam int TABLE_N  = (TABLE_POINTS > bgt_pkg::TABLE_HAVE) ? bgt_pkg::TABLE_HAVE :
                            ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam logic [CW-1:0] CNT_LAST = CW'(N - 1);
  localparam logic [CW-1:0] KEEP_LO  = CW'(TRIM);
  localparam logic [CW-1:0] KEEP_HI  = CW'(N - TRIM);
  localparam logic [bgt_pkg::SEG_W-1:0] SEG_BOT  = bgt_pkg::SEG_W'(TABLE_N - 1);
  localparam logic [bgt_pkg::SEG_W-1:0] SEG_LAST = bgt_pkg::SEG_W'(TABLE_N - 2);

  // reciprocal of the kept count, exact floor for every sum below 2^SW
  localparam int RK = SW + CW;
  localparam int RW = RK + 1;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RK) + 64'(KEEP) - 64'd1) / 64'(KEEP));
  localparam int PRODW = bgt_pkg::Q14_W - 1;

  localparam int FW = bgt_pkg::FILT_W;
  localparam int PW = bgt_pkg::PCT_W;
  localparam int DW = bgt_pkg::DIV_DW;
  localparam int VW = bgt_pkg::DIV_VW;

  // configuration registers
  logic [14:0]   gain;
  logic [15:0]   alpha;
  logic [PW-1:0] low_enter;
  logic [PW-1:0] low_leave;
  logic [3:0]    rise;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= bgt_pkg::GAIN_RST;
      alpha     <= bgt_pkg::ALPHA_RST;
      low_enter <= bgt_pkg::LOW_ENTER_RST;
      low_leave <= bgt_pkg::LOW_LEAVE_RST;
      rise      <= bgt_pkg::RISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bgt_pkg::REG_GAIN:      gain      <= cfg_data[14:0];
        bgt_pkg::REG_ALPHA:     alpha     <= cfg_data;
        bgt_pkg::REG_LOW_ENTER: low_enter <= cfg_data[PW-1:0];
        bgt_pkg::REG_LOW_LEAVE: low_leave <= cfg_data[PW-1:0];
        bgt_pkg::REG_RISE:      rise      <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // state
  bgt_pkg::bgt_state_t state, state_next;
  logic [CW-1:0]       count;
  logic                force_r;
  logic [SW-1:0]       sum;
  logic [bgt_pkg::SAMPLE_W-1:0] avg;
  logic [bgt_pkg::Q14_W-1:0]    q14;
  logic                valid_r;
  logic [13:0]         bmv;
  logic [FW-1:0]       r16;
  logic [33:0]         acc;
  logic [FW-1:0]       filt;
  logic [bgt_pkg::SEG_W-1:0] seg;
  logic [PW-1:0]       plo;
  logic [PW-1:0]       raw;
  logic [PW-1:0]       shown;
  logic                low;

  logic accept;
  assign accept = start && !busy;

  // sorting row
  bgt_pkg::cell_ctl_t           cell_ctl;
  logic [bgt_pkg::SAMPLE_W-1:0] vals [N];
  logic [N-1:0]                 gts;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [bgt_pkg::SAMPLE_W-1:0] pv;
    logic [bgt_pkg::SAMPLE_W-1:0] nv;
    logic                         pg;
    if (i == 0) begin : g_first
      assign pv = '0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pv = vals[i-1];
      assign pg = gts[i-1];
    end
    if (i == N - 1) begin : g_last
      assign nv = vals[i];
    end else begin : g_nlast
      assign nv = vals[i+1];
    end
    bgt_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .occ      (CW'(i) < count),
      .at_end   (CW'(i) == count),
      .prev_gt  (pg),
      .prev_val (pv),
      .next_val (nv),
      .val      (vals[i]),
      .gt       (gts[i])
    );
  end

  // table segment under test
  logic [FW-1:0] seg_hi, seg_lo, tab_top, tab_bot;
  logic          seg_found;
  logic [PW-1:0] seg_phi, seg_plo, seg_span;
  logic [13:0]   seg_off, seg_den;
  logic [20:0]   seg_num;

  assign seg_hi    = {bgt_pkg::ocv_mv(seg), 4'b0000};
  assign seg_lo    = {bgt_pkg::ocv_mv(seg + 1'b1), 4'b0000};
  assign tab_top   = {bgt_pkg::ocv_mv('0), 4'b0000};
  assign tab_bot   = {bgt_pkg::ocv_mv(SEG_BOT), 4'b0000};
  assign seg_found = (filt <= seg_hi) && (filt >= seg_lo) && (seg_hi > seg_lo);
  assign seg_phi   = bgt_pkg::ocv_pct(seg);
  assign seg_plo   = bgt_pkg::ocv_pct(seg + 1'b1);
  assign seg_span  = (seg_phi >= seg_plo) ? seg_phi - seg_plo : '0;
  assign seg_off   = 14'(filt - seg_lo);
  assign seg_den   = 14'(seg_hi - seg_lo);
  assign seg_num   = seg_off * seg_span;

  // divider for the table interpolation
  logic          div_start, div_done;
  logic [DW-1:0] div_a, div_q;
  logic [VW-1:0] div_b;

  assign div_a = DW'({seg_num, 1'b0} + 22'(seg_den));
  assign div_b = {seg_den, 1'b0};

  bgt_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // trimmed average by reciprocal multiply
  logic [SW+RW-1:0] avg_prod;
  assign avg_prod = (SW+RW)'(sum) * (SW+RW)'(RECIP);

  logic at_top, at_bot;
  assign at_top = filt >= tab_top;
  assign at_bot = filt <= tab_bot;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bgt_pkg::S_FILL:  if (accept && count == CNT_LAST) state_next = bgt_pkg::S_SUM;
      bgt_pkg::S_SUM:   if (count == CNT_LAST) state_next = bgt_pkg::S_AVG;
      bgt_pkg::S_AVG:   state_next = bgt_pkg::S_SCALE;
      bgt_pkg::S_SCALE: state_next = bgt_pkg::S_CHECK;
      bgt_pkg::S_CHECK: begin
        if (q14 > bgt_pkg::VALID_LO_Q14 && q14 < bgt_pkg::VALID_HI_Q14) begin
          state_next = bgt_pkg::S_MUL1;
        end else begin
          state_next = bgt_pkg::S_OUT;
        end
      end
      bgt_pkg::S_MUL1:  state_next = bgt_pkg::S_MUL2;
      bgt_pkg::S_MUL2:  state_next = bgt_pkg::S_CLAMP;
      bgt_pkg::S_CLAMP: state_next = bgt_pkg::S_SEEK;
      bgt_pkg::S_SEEK: begin
        if (at_top || at_bot) begin
          state_next = bgt_pkg::S_SLEW;
        end else if (seg_found) begin
          state_next = bgt_pkg::S_PCT;
        end else if (seg == SEG_LAST) begin
          state_next = bgt_pkg::S_SLEW;
        end
      end
      bgt_pkg::S_PCT:   if (div_done) state_next = bgt_pkg::S_SLEW;
      bgt_pkg::S_SLEW:  state_next = bgt_pkg::S_OUT;
      bgt_pkg::S_OUT:   state_next = bgt_pkg::S_FILL;
      default:          state_next = bgt_pkg::S_FILL;
    endcase
  end

  // control outputs
  always_comb begin
    busy            = (state != bgt_pkg::S_FILL);
    done            = (state == bgt_pkg::S_OUT);
    cell_ctl.cmd    = bgt_pkg::CELL_HOLD;
    cell_ctl.sample = item.sample_mv;
    div_start       = 1'b0;
    case (state)
      bgt_pkg::S_FILL: if (accept) cell_ctl.cmd = bgt_pkg::CELL_INSERT;
      bgt_pkg::S_SUM: begin
        cell_ctl.cmd = bgt_pkg::CELL_DRAIN;
        div_start    = 1'b0;
      end
      bgt_pkg::S_SEEK: div_start = !at_top && !at_bot && seg_found;
      default: begin
      end
    endcase
  end

  // slew and low flag
  logic [PW-1:0] shown_next;
  logic          low_next;
  always_comb begin
    shown_next = shown;
    if (force_r) begin
      shown_next = raw;
    end else if (raw < shown) begin
      shown_next = shown - 1'b1;
    end else if ({1'b0, raw} > ({1'b0, shown} + {4'b0000, rise})) begin
      shown_next = shown + 1'b1;
    end
    if (shown_next > bgt_pkg::PCT_FULL) shown_next = bgt_pkg::PCT_FULL;
    low_next = low;
    if (!low && shown_next <= low_enter) begin
      low_next = 1'b1;
    end else if (low && shown_next >= low_leave) begin
      low_next = 1'b0;
    end
  end

  // filter candidate and clamp
  logic [FW:0]   f_pre;
  logic [FW-1:0] f_clamped;
  logic [22:0]   pct_sum;
  assign f_pre = (filt == '0) ? {1'b0, r16} : acc[33:16];
  always_comb begin
    if (f_pre < {1'b0, bgt_pkg::CLAMP_LO_16}) begin
      f_clamped = bgt_pkg::CLAMP_LO_16;
    end else if (f_pre > {1'b0, bgt_pkg::CLAMP_HI_16}) begin
      f_clamped = bgt_pkg::CLAMP_HI_16;
    end else begin
      f_clamped = f_pre[FW-1:0];
    end
  end
  assign pct_sum = {16'd0, plo} + {1'b0, div_q};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bgt_pkg::S_FILL;
      count   <= '0;
      filt    <= '0;
      raw     <= '0;
      shown   <= '0;
      low     <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        bgt_pkg::S_FILL: begin
          if (accept) begin
            count <= (count == CNT_LAST) ? '0 : count + 1'b1;
          end
        end
        bgt_pkg::S_SUM:   count <= (count == CNT_LAST) ? '0 : count + 1'b1;
        bgt_pkg::S_CHECK: valid_r <= q14 > bgt_pkg::VALID_LO_Q14 &&
                                     q14 < bgt_pkg::VALID_HI_Q14;
        bgt_pkg::S_CLAMP: filt <= f_clamped;
        bgt_pkg::S_SEEK: begin
          if (at_top) begin
            raw <= (bgt_pkg::ocv_pct('0) > bgt_pkg::PCT_FULL) ? bgt_pkg::PCT_FULL :
                   bgt_pkg::ocv_pct('0);
          end else if (at_bot || (!seg_found && seg == SEG_LAST)) begin
            raw <= '0;
          end
        end
        bgt_pkg::S_PCT: begin
          if (div_done) begin
            raw <= (pct_sum > 23'(bgt_pkg::PCT_FULL)) ? bgt_pkg::PCT_FULL : pct_sum[PW-1:0];
          end
        end
        bgt_pkg::S_SLEW: begin
          shown <= shown_next;
          low   <= low_next;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bgt_pkg::S_FILL: begin
        force_r <= item.force_req;
        sum     <= '0;
      end
      bgt_pkg::S_SUM: begin
        if (count >= KEEP_LO && count < KEEP_HI) begin
          sum <= sum + SW'(vals[0]);
        end
      end
      bgt_pkg::S_AVG:   avg <= avg_prod[RK +: bgt_pkg::SAMPLE_W];
      bgt_pkg::S_SCALE: q14 <= {PRODW'(avg) * PRODW'(gain), 1'b0};
      bgt_pkg::S_CHECK: begin
        bmv <= q14[27:14];
        r16 <= q14[26:10];
      end
      bgt_pkg::S_MUL1:  acc <= 34'(alpha) * 34'(r16);
      bgt_pkg::S_MUL2:  acc <= acc + 34'(bgt_pkg::ALPHA_ONE - {1'b0, alpha}) * 34'(filt) +
                               bgt_pkg::ROUND_HALF;
      bgt_pkg::S_CLAMP: seg <= '0;
      bgt_pkg::S_SEEK: begin
        plo <= seg_plo;
        if (!seg_found) seg <= seg + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result fields
  assign result.reading_valid = valid_r;
  assign result.battery_mv    = bmv;
  assign result.filtered_mv   = filt[16:4];
  assign result.raw_percent   = raw;
  assign result.shown_percent = shown;
  assign result.battery_low   = low;

`ifndef ASSERT_OFF
  // a result lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  // the closing sample starts the batch pass
  a_batch_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && count == CNT_LAST) |=> busy)
    else $error("batch pass did not start");
  // the divider is never restarted while the sequencer waits on it
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == bgt_pkg::S_PCT) |-> !div_start)
    else $error("divider restarted mid-division");
  // shown percentage stays in range
  a_shown_rng: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.shown_percent <= bgt_pkg::PCT_FULL))
    else $error("shown percent out of range");
`endif

endmodule
